[hdl/cltr_pkg.sv]
// Shared constants for the line-to-rectangle clipping core.
`default_nettype none
package cltr_pkg;
  localparam int COORD_WIDTH_DEF = 24;
  localparam int DIR_WIDTH_DEF   = 16;
  localparam int EDGE_W          = 22;
  localparam int NEAR_Q8         = 512;
  localparam int NEAR_SQ         = NEAR_Q8 * NEAR_Q8;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_LEFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd3;

  localparam logic [1:0] PAIR_A [6] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam logic [1:0] PAIR_B [6] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

  function automatic logic [2:0] pair_of(input logic [1:0] a, input logic [1:0] b);
    logic [1:0] lo;
    logic [1:0] hi;
    logic [2:0] r;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    unique case ({lo, hi})
      4'b0001: r = 3'd0;
      4'b0010: r = 3'd1;
      4'b0011: r = 3'd2;
      4'b0110: r = 3'd3;
      4'b0111: r = 3'd4;
      4'b1011: r = 3'd5;
      default: r = 3'd0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

[hdl/clip_line_to_rectangle_core.sv]
// Line to rectangle clipping core: pipelined edge crossings, dedupe and longest pair.
//
//  channel   handshake               payload
//  request   start_i / busy_o        dir_x_i dir_y_i point_x_i point_y_i
//  result    out_valid_o strobe      seg_valid_o start_x_o start_y_o end_x_o end_y_o
//  config    cfg_valid_i/cfg_ready_o cfg_index_i cfg_data_i
//
// One request per cycle; busy_o stays low.
// The divider resolves one quotient bit per stage.
// Reset clears the stage valid bits and loads the default rectangle.
// The result strobe cannot be held off, so the pipeline never stalls.
`default_nettype none
module clip_line_to_rectangle_core #(
  parameter int COORD_WIDTH = cltr_pkg::COORD_WIDTH_DEF,
  parameter int DIR_WIDTH   = cltr_pkg::DIR_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic signed [DIR_WIDTH-1:0]        dir_x_i,
  input  logic signed [DIR_WIDTH-1:0]        dir_y_i,
  input  logic signed [COORD_WIDTH-1:0]      point_x_i,
  input  logic signed [COORD_WIDTH-1:0]      point_y_i,
  output logic                               out_valid_o,
  output logic                               seg_valid_o,
  output logic signed [COORD_WIDTH-1:0]      start_x_o,
  output logic signed [COORD_WIDTH-1:0]      start_y_o,
  output logic signed [COORD_WIDTH-1:0]      end_x_o,
  output logic signed [COORD_WIDTH-1:0]      end_y_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [cltr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [cltr_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import cltr_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = DIR_WIDTH;
  localparam int EW   = EDGE_W;
  localparam int DIFW = ((EW + 1 > CW) ? EW + 1 : CW) + 1;
  localparam int PW   = DIFW + DW;
  localparam int NW   = PW + 1;
  localparam int XW   = EW + CW;
  localparam int SQW  = 2 * CW + 2;
  localparam int D2W  = SQW + 1;
  localparam logic signed [CW-1:0] C_HI  = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] C_LO  = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] C_NONE = -CW'(256);

  // configuration
  logic [11:0] left_q, top_q;
  logic [12:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      top_q    <= '0;
      width_q  <= 13'd4096;
      height_q <= 13'd4096;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_LEFT:   left_q   <= cfg_data_i[11:0];
        CFG_TOP:    top_q    <= cfg_data_i[11:0];
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  logic [EW-1:0] left_e, right_e, top_e, bot_e;
  assign left_e  = {2'b00, left_q, 8'd0};
  assign top_e   = {2'b00, top_q, 8'd0};
  assign right_e = {(14'(left_q) + 14'(width_q)), 8'd0};
  assign bot_e   = {(14'(top_q) + 14'(height_q)), 8'd0};

  function automatic logic signed [CW-1:0] sat_edge(input logic [EW-1:0] e);
    if (XW'(e) > XW'(C_HI)) return C_HI;
    return CW'(e);
  endfunction

  function automatic logic signed [CW-1:0] sat_quo(input logic [CW-1:0] q,
                                                   input logic neg, input logic ovf);
    if (neg) begin
      if (ovf || (q > C_LO)) return C_LO;
      return CW'(~q + 1'b1);
    end
    if (ovf || (q > C_HI)) return C_HI;
    return CW'(q);
  endfunction

  // stage A: edge differences
  logic                   a_v_q;
  logic signed [DIFW-1:0] a_dl_q, a_dr_q, a_dt_q, a_db_q;
  logic signed [DW-1:0]   a_dx_q, a_dy_q;
  logic signed [CW-1:0]   a_px_q, a_py_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_v_q <= 1'b0;
    else         a_v_q <= start_i && !busy_o;
  end

  always_ff @(posedge clk_i) begin
    a_dl_q <= $signed(DIFW'(left_e))  - DIFW'(point_x_i);
    a_dr_q <= $signed(DIFW'(right_e)) - DIFW'(point_x_i);
    a_dt_q <= $signed(DIFW'(top_e))   - DIFW'(point_y_i);
    a_db_q <= $signed(DIFW'(bot_e))   - DIFW'(point_y_i);
    a_dx_q <= dir_x_i;
    a_dy_q <= dir_y_i;
    a_px_q <= point_x_i;
    a_py_q <= point_y_i;
  end

  // stage B: products
  logic                 b_v_q;
  logic signed [PW-1:0] b_m_q [4];
  logic signed [PW-1:0] b_mx_q, b_my_q;
  logic signed [DW-1:0] b_dx_q, b_dy_q;
  logic signed [CW-1:0] b_px_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b_v_q <= 1'b0;
    else         b_v_q <= a_v_q;
  end

  always_ff @(posedge clk_i) begin
    b_m_q[0] <= PW'(a_dy_q) * PW'(a_dl_q);
    b_m_q[1] <= PW'(a_dy_q) * PW'(a_dr_q);
    b_m_q[2] <= PW'(a_dx_q) * PW'(a_dt_q);
    b_m_q[3] <= PW'(a_dx_q) * PW'(a_db_q);
    b_mx_q   <= PW'(a_dx_q) * PW'(a_py_q);
    b_my_q   <= PW'(a_dy_q) * PW'(a_px_q);
    b_dx_q   <= a_dx_q;
    b_dy_q   <= a_dy_q;
    b_px_q   <= a_px_q;
  end

  // stage C: numerators
  logic                 c_v_q;
  logic signed [NW-1:0] c_n_q [4];
  logic signed [DW-1:0] c_dx_q, c_dy_q;
  logic signed [CW-1:0] c_px_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c_v_q <= 1'b0;
    else         c_v_q <= b_v_q;
  end

  always_ff @(posedge clk_i) begin
    c_n_q[0] <= NW'(b_m_q[0]) + NW'(b_mx_q);
    c_n_q[1] <= NW'(b_m_q[1]) + NW'(b_mx_q);
    c_n_q[2] <= NW'(b_m_q[2]) + NW'(b_my_q);
    c_n_q[3] <= NW'(b_m_q[3]) + NW'(b_my_q);
    c_dx_q   <= b_dx_q;
    c_dy_q   <= b_dy_q;
    c_px_q   <= b_px_q;
  end

  // stage D and divider stages, one quotient bit per stage
  logic [NW-1:0]        dv_rem_q  [CW+1][4];
  logic [DW-1:0]        dv_den_q  [CW+1][4];
  logic [CW-1:0]        dv_quo_q  [CW+1][4];
  logic                 dv_neg_q  [CW+1][4];
  logic                 dv_ovf_q  [CW+1][4];
  logic                 dv_v_q    [CW+1];
  logic                 dv_vert_q [CW+1];
  logic                 dv_dyz_q  [CW+1];
  logic signed [CW-1:0] dv_px_q   [CW+1];

  logic [NW-1:0] d_num_d [4];
  logic [DW-1:0] d_den_d [4];
  logic          d_neg_d [4];
  logic          d_ovf_d [4];

  always_comb begin
    logic signed [DW-1:0] den;
    for (int k = 0; k < 4; k++) begin
      den        = (k < 2) ? c_dx_q : c_dy_q;
      d_num_d[k] = c_n_q[k][NW-1] ? NW'(-c_n_q[k]) : NW'(c_n_q[k]);
      d_den_d[k] = den[DW-1] ? DW'(-den) : DW'(den);
      d_neg_d[k] = c_n_q[k][NW-1] ^ den[DW-1];
      d_ovf_d[k] = d_num_d[k] >= (NW'(d_den_d[k]) << CW);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_v_q[0] <= 1'b0;
    else         dv_v_q[0] <= c_v_q;
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      dv_rem_q[0][k] <= d_num_d[k];
      dv_den_q[0][k] <= d_den_d[k];
      dv_quo_q[0][k] <= '0;
      dv_neg_q[0][k] <= d_neg_d[k];
      dv_ovf_q[0][k] <= d_ovf_d[k];
    end
    dv_vert_q[0] <= (c_dx_q == '0);
    dv_dyz_q[0]  <= (c_dy_q == '0);
    dv_px_q[0]   <= c_px_q;
  end

  for (genvar s = 0; s < CW; s++) begin : g_div
    localparam int B = CW - 1 - s;
    logic [NW-1:0] rem_d [4];
    logic [CW-1:0] quo_d [4];

    always_comb begin
      logic [NW-1:0] sh;
      for (int k = 0; k < 4; k++) begin
        sh       = NW'(dv_den_q[s][k]) << B;
        rem_d[k] = dv_rem_q[s][k];
        quo_d[k] = dv_quo_q[s][k];
        if (dv_rem_q[s][k] >= sh) begin
          rem_d[k]    = dv_rem_q[s][k] - sh;
          quo_d[k][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_v_q[s+1] <= 1'b0;
      else         dv_v_q[s+1] <= dv_v_q[s];
    end

    always_ff @(posedge clk_i) begin
      for (int k = 0; k < 4; k++) begin
        dv_rem_q[s+1][k] <= rem_d[k];
        dv_den_q[s+1][k] <= dv_den_q[s][k];
        dv_quo_q[s+1][k] <= quo_d[k];
        dv_neg_q[s+1][k] <= dv_neg_q[s][k];
        dv_ovf_q[s+1][k] <= dv_ovf_q[s][k];
      end
      dv_vert_q[s+1] <= dv_vert_q[s];
      dv_dyz_q[s+1]  <= dv_dyz_q[s];
      dv_px_q[s+1]   <= dv_px_q[s];
    end
  end

  // stage S: saturated crossing points
  logic                 s_v_q, s_vert_q, s_dyz_q;
  logic signed [CW-1:0] s_x_q [4];
  logic signed [CW-1:0] s_y_q [4];
  logic signed [CW-1:0] s_px_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s_v_q <= 1'b0;
    else         s_v_q <= dv_v_q[CW];
  end

  always_ff @(posedge clk_i) begin
    s_x_q[0] <= sat_edge(left_e);
    s_y_q[0] <= sat_quo(dv_quo_q[CW][0], dv_neg_q[CW][0], dv_ovf_q[CW][0]);
    s_x_q[1] <= sat_edge(right_e);
    s_y_q[1] <= sat_quo(dv_quo_q[CW][1], dv_neg_q[CW][1], dv_ovf_q[CW][1]);
    s_x_q[2] <= sat_quo(dv_quo_q[CW][2], dv_neg_q[CW][2], dv_ovf_q[CW][2]);
    s_y_q[2] <= sat_edge(top_e);
    s_x_q[3] <= sat_quo(dv_quo_q[CW][3], dv_neg_q[CW][3], dv_ovf_q[CW][3]);
    s_y_q[3] <= sat_edge(bot_e);
    s_vert_q <= dv_vert_q[CW];
    s_dyz_q  <= dv_dyz_q[CW];
    s_px_q   <= dv_px_q[CW];
  end

  // stage P2: span and edge flags, pair distances
  logic                 p2_v_q, p2_vert_q;
  logic [3:0]           p2_cand_q, p2_near_q, p2_ex_q;
  logic [CW:0]          p2_ax_q [6];
  logic [CW:0]          p2_ay_q [6];
  logic signed [CW-1:0] p2_x_q [4];
  logic signed [CW-1:0] p2_y_q [4];
  logic signed [CW-1:0] p2_px_q;

  logic [3:0] p2_cand_d, p2_near_d, p2_ex_d;
  logic [CW:0] p2_ax_d [6];
  logic [CW:0] p2_ay_d [6];

  always_comb begin
    logic signed [DIFW-1:0] c, lo_e, hi_e, dl, dh;
    logic signed [CW:0]     ddx, ddy;
    for (int k = 0; k < 4; k++) begin
      c    = (k < 2) ? DIFW'(s_y_q[k]) : DIFW'(s_x_q[k]);
      lo_e = (k < 2) ? $signed(DIFW'(top_e)) : $signed(DIFW'(left_e));
      hi_e = (k < 2) ? $signed(DIFW'(bot_e)) : $signed(DIFW'(right_e));
      dl   = c - lo_e;
      dh   = c - hi_e;
      p2_ex_d[k]   = (k < 2) ? 1'b1 : !s_dyz_q;
      p2_cand_d[k] = p2_ex_d[k] && (c >= lo_e) && (c <= hi_e);
      p2_near_d[k] = p2_ex_d[k] && ((dl < NEAR_Q8 && dl > -NEAR_Q8) ||
                                    (dh < NEAR_Q8 && dh > -NEAR_Q8));
    end
    for (int p = 0; p < 6; p++) begin
      ddx = (CW+1)'(s_x_q[PAIR_A[p]]) - (CW+1)'(s_x_q[PAIR_B[p]]);
      ddy = (CW+1)'(s_y_q[PAIR_A[p]]) - (CW+1)'(s_y_q[PAIR_B[p]]);
      p2_ax_d[p] = ddx[CW] ? (CW+1)'(-ddx) : (CW+1)'(ddx);
      p2_ay_d[p] = ddy[CW] ? (CW+1)'(-ddy) : (CW+1)'(ddy);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p2_v_q <= 1'b0;
    else         p2_v_q <= s_v_q;
  end

  always_ff @(posedge clk_i) begin
    p2_cand_q <= p2_cand_d;
    p2_near_q <= p2_near_d;
    p2_ex_q   <= p2_ex_d;
    p2_ax_q   <= p2_ax_d;
    p2_ay_q   <= p2_ay_d;
    p2_x_q    <= s_x_q;
    p2_y_q    <= s_y_q;
    p2_vert_q <= s_vert_q;
    p2_px_q   <= s_px_q;
  end

  // stage P3: squares and duplicate test
  logic                 p3_v_q, p3_vert_q;
  logic [3:0]           p3_cand_q, p3_near_q, p3_ex_q;
  logic [5:0]           p3_same_q;
  logic [SQW-1:0]       p3_sx_q [6];
  logic [SQW-1:0]       p3_sy_q [6];
  logic signed [CW-1:0] p3_x_q [4];
  logic signed [CW-1:0] p3_y_q [4];
  logic signed [CW-1:0] p3_px_q;

  logic [5:0] p3_same_d;

  always_comb begin
    logic [18:0] s2;
    for (int p = 0; p < 6; p++) begin
      s2 = 19'(p2_ax_q[p][8:0]) * 19'(p2_ax_q[p][8:0]) +
           19'(p2_ay_q[p][8:0]) * 19'(p2_ay_q[p][8:0]);
      p3_same_d[p] = (p2_ax_q[p] < (CW+1)'(NEAR_Q8)) && (p2_ay_q[p] < (CW+1)'(NEAR_Q8)) &&
                     (s2 < 19'(NEAR_SQ));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p3_v_q <= 1'b0;
    else         p3_v_q <= p2_v_q;
  end

  always_ff @(posedge clk_i) begin
    for (int p = 0; p < 6; p++) begin
      p3_sx_q[p] <= SQW'(p2_ax_q[p]) * SQW'(p2_ax_q[p]);
      p3_sy_q[p] <= SQW'(p2_ay_q[p]) * SQW'(p2_ay_q[p]);
    end
    p3_same_q <= p3_same_d;
    p3_cand_q <= p2_cand_q;
    p3_near_q <= p2_near_q;
    p3_ex_q   <= p2_ex_q;
    p3_x_q    <= p2_x_q;
    p3_y_q    <= p2_y_q;
    p3_vert_q <= p2_vert_q;
    p3_px_q   <= p2_px_q;
  end

  // stage P4: kept list and pair lengths
  logic                 p4_v_q, p4_vert_q;
  logic [2:0]           p4_n_q;
  logic [1:0]           p4_slot_q [4];
  logic [D2W-1:0]       p4_d2_q [6];
  logic signed [CW-1:0] p4_x_q [4];
  logic signed [CW-1:0] p4_y_q [4];
  logic signed [CW-1:0] p4_px_q;

  logic [2:0] p4_n_d;
  logic [1:0] p4_slot_d [4];

  always_comb begin
    logic [3:0] kept1, kept2;
    logic       hit;
    logic [2:0] n1;
    kept1 = '0;
    kept2 = '0;
    for (int k = 0; k < 4; k++) begin
      hit = 1'b0;
      for (int m = 0; m < 4; m++)
        if (m < k && kept1[m] && p3_same_q[pair_of(2'(k), 2'(m))]) hit = 1'b1;
      kept1[k] = p3_cand_q[k] && !hit;
    end
    n1 = 3'($countones(kept1));
    if (n1 < 3'd2) begin
      for (int k = 0; k < 4; k++) begin
        hit = 1'b0;
        for (int m = 0; m < 4; m++)
          if (m != k && (kept1[m] || (m < k && kept2[m])) &&
              p3_same_q[pair_of(2'(k), 2'(m))]) hit = 1'b1;
        kept2[k] = p3_ex_q[k] && !kept1[k] && p3_near_q[k] && !hit;
      end
    end
    p4_n_d = '0;
    for (int s = 0; s < 4; s++) p4_slot_d[s] = '0;
    for (int k = 0; k < 4; k++) begin
      if (kept1[k] && p4_n_d < 3'd4) begin
        p4_slot_d[p4_n_d[1:0]] = 2'(k);
        p4_n_d = p4_n_d + 3'd1;
      end
    end
    for (int k = 0; k < 4; k++) begin
      if (kept2[k] && p4_n_d < 3'd4) begin
        p4_slot_d[p4_n_d[1:0]] = 2'(k);
        p4_n_d = p4_n_d + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p4_v_q <= 1'b0;
    else         p4_v_q <= p3_v_q;
  end

  always_ff @(posedge clk_i) begin
    for (int p = 0; p < 6; p++) p4_d2_q[p] <= D2W'(p3_sx_q[p]) + D2W'(p3_sy_q[p]);
    p4_n_q    <= p4_n_d;
    p4_slot_q <= p4_slot_d;
    p4_x_q    <= p3_x_q;
    p4_y_q    <= p3_y_q;
    p4_vert_q <= p3_vert_q;
    p4_px_q   <= p3_px_q;
  end

  // stage P5: first level of the longest-pair search
  logic                 p5_v_q, p5_vert_q, p5_two_q;
  logic [2:0]           p5_ok_q;
  logic [D2W-1:0]       p5_len_q [3];
  logic [1:0]           p5_a_q [3];
  logic [1:0]           p5_b_q [3];
  logic signed [CW-1:0] p5_x_q [4];
  logic signed [CW-1:0] p5_y_q [4];
  logic signed [CW-1:0] p5_px_q;

  logic [D2W-1:0] lp_len [6];
  logic [5:0]     lp_ok;
  logic [1:0]     lp_a [6];
  logic [1:0]     lp_b [6];
  logic [2:0]     p5_ok_d;
  logic [D2W-1:0] p5_len_d [3];
  logic [1:0]     p5_a_d [3];
  logic [1:0]     p5_b_d [3];

  always_comb begin
    for (int p = 0; p < 6; p++) begin
      lp_a[p]   = p4_slot_q[PAIR_A[p]];
      lp_b[p]   = p4_slot_q[PAIR_B[p]];
      lp_len[p] = p4_d2_q[pair_of(lp_a[p], lp_b[p])];
      lp_ok[p]  = 3'(PAIR_B[p]) < p4_n_q;
    end
    for (int g = 0; g < 3; g++) begin
      if (lp_ok[2*g+1] && (!lp_ok[2*g] || lp_len[2*g+1] > lp_len[2*g])) begin
        p5_ok_d[g]  = 1'b1;
        p5_len_d[g] = lp_len[2*g+1];
        p5_a_d[g]   = lp_a[2*g+1];
        p5_b_d[g]   = lp_b[2*g+1];
      end else begin
        p5_ok_d[g]  = lp_ok[2*g];
        p5_len_d[g] = lp_len[2*g];
        p5_a_d[g]   = lp_a[2*g];
        p5_b_d[g]   = lp_b[2*g];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p5_v_q <= 1'b0;
    else         p5_v_q <= p4_v_q;
  end

  always_ff @(posedge clk_i) begin
    p5_ok_q   <= p5_ok_d;
    p5_len_q  <= p5_len_d;
    p5_a_q    <= p5_a_d;
    p5_b_q    <= p5_b_d;
    p5_two_q  <= p4_n_q >= 3'd2;
    p5_x_q    <= p4_x_q;
    p5_y_q    <= p4_y_q;
    p5_vert_q <= p4_vert_q;
    p5_px_q   <= p4_px_q;
  end

  // stage P6: final pick and output register
  logic [1:0] fin_a, fin_b;

  always_comb begin
    logic           ok;
    logic [D2W-1:0] len;
    ok    = p5_ok_q[0];
    len   = p5_len_q[0];
    fin_a = p5_a_q[0];
    fin_b = p5_b_q[0];
    for (int g = 1; g < 3; g++) begin
      if (p5_ok_q[g] && (!ok || p5_len_q[g] > len)) begin
        ok    = 1'b1;
        len   = p5_len_q[g];
        fin_a = p5_a_q[g];
        fin_b = p5_b_q[g];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else         out_valid_o <= p5_v_q;
  end

  always_ff @(posedge clk_i) begin
    priority if (p5_vert_q) begin
      seg_valid_o <= 1'b1;
      start_x_o   <= p5_px_q;
      start_y_o   <= p5_y_q[2];
      end_x_o     <= p5_px_q;
      end_y_o     <= p5_y_q[3];
    end else if (p5_two_q) begin
      seg_valid_o <= 1'b1;
      start_x_o   <= p5_x_q[fin_a];
      start_y_o   <= p5_y_q[fin_a];
      end_x_o     <= p5_x_q[fin_b];
      end_y_o     <= p5_y_q[fin_b];
    end else begin
      seg_valid_o <= 1'b0;
      start_x_o   <= C_NONE;
      start_y_o   <= C_NONE;
      end_x_o     <= C_NONE;
      end_y_o     <= C_NONE;
    end
  end
endmodule
`default_nettype wire

[hdl/cltr_checker.sv]
// Port-level checks for the clipping core, bound to its top level.
`default_nettype none
module cltr_checker #(
  parameter int COORD_WIDTH = cltr_pkg::COORD_WIDTH_DEF,
  parameter int DIR_WIDTH   = cltr_pkg::DIR_WIDTH_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic signed [DIR_WIDTH-1:0]   dir_x_i,
  input logic signed [COORD_WIDTH-1:0] point_x_i,
  input logic                          out_valid_o,
  input logic                          seg_valid_o,
  input logic signed [COORD_WIDTH-1:0] start_x_o,
  input logic signed [COORD_WIDTH-1:0] start_y_o,
  input logic signed [COORD_WIDTH-1:0] end_x_o,
  input logic signed [COORD_WIDTH-1:0] end_y_o
);
  localparam int LAT = COORD_WIDTH + 10;
  localparam int AW  = $clog2(LAT + 1);
  localparam logic signed [COORD_WIDTH-1:0] NONE = -COORD_WIDTH'(256);

  logic [AW-1:0] age_q;
  logic          aged;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) age_q <= '0;
    else if (age_q != AW'(LAT)) age_q <= age_q + 1'b1;
  end

  assign aged = (age_q == AW'(LAT));

  a_no_seg_coords: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !seg_valid_o |-> start_x_o == NONE && start_y_o == NONE &&
                                    end_x_o == NONE && end_y_o == NONE)
    else $error("empty result with coordinates other than -1 pixel");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    aged |-> out_valid_o == $past(start_i && !busy_o, LAT))
    else $error("result strobe does not match an accepted request");

  a_vertical: assert property (@(posedge clk_i) disable iff (!rst_ni)
    aged && $past(start_i && !busy_o && dir_x_i == '0, LAT) |->
      seg_valid_o && start_x_o == $past(point_x_i, LAT) && end_x_o == start_x_o)
    else $error("vertical line result wrong");

  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !busy_o)
    else $error("busy while delivering a result");
endmodule

bind clip_line_to_rectangle_core cltr_checker #(
  .COORD_WIDTH(COORD_WIDTH),
  .DIR_WIDTH  (DIR_WIDTH)
) u_cltr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .busy_o     (busy_o),
  .dir_x_i    (dir_x_i),
  .point_x_i  (point_x_i),
  .out_valid_o(out_valid_o),
  .seg_valid_o(seg_valid_o),
  .start_x_o  (start_x_o),
  .start_y_o  (start_y_o),
  .end_x_o    (end_x_o),
  .end_y_o    (end_y_o)
);
`default_nettype wire
